// File: rtl/loc_pkg.sv
// ----------------------------------------------------------------------------
// loc_pkg
// shared types and codes of the lock-order checker
// ----------------------------------------------------------------------------
`default_nettype none

package loc_pkg;

	localparam int OBJ_W = 16;

	localparam logic [2:0] CMD_LOCK      = 3'd0;
	localparam logic [2:0] CMD_UNLOCK    = 3'd1;
	localparam logic [2:0] CMD_CLR_STACK = 3'd2;
	localparam logic [2:0] CMD_CLR_GRAPH = 3'd3;
	localparam logic [2:0] CMD_REMOVE    = 3'd4;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_HELD     = 3'd1;
	localparam logic [2:0] ST_ORDER    = 3'd2;
	localparam logic [2:0] ST_EMPTY    = 3'd3;
	localparam logic [2:0] ST_MISORDER = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	typedef struct packed {
		logic [2:0]       command;
		logic [OBJ_W-1:0] object_id;
	} loc_in_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [OBJ_W-1:0] other_object;
		logic             graph_full;
	} loc_out_t;

	typedef struct packed {
		logic [OBJ_W-1:0] first;
		logic [OBJ_W-1:0] second;
	} loc_pair_t;

	typedef struct packed {
		logic vld;
		logic fwd;
		logic rev;
		logic free;
	} loc_hit_t;

endpackage

`default_nettype wire

// File: rtl/loc_pair_table.sv
// ----------------------------------------------------------------------------
// loc_pair_table
// learned order pair memory with valid bits and the shared entry comparator
// ----------------------------------------------------------------------------
`default_nettype none

module loc_pair_table import loc_pkg::*; #(
	parameter int PAIR_ENTRIES = 256,
	localparam int PW = $clog2(PAIR_ENTRIES)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [PW-1:0]    rd_addr,
	input  wire logic [OBJ_W-1:0] key_a,
	input  wire logic [OBJ_W-1:0] key_b,
	input  wire logic             kill_en,
	input  wire logic             clr_all,
	input  wire logic             wr_en,
	input  wire logic [PW-1:0]    wr_addr,
	input  wire loc_pair_t        wr_data,
	output loc_hit_t              hit,
	output logic [PW-1:0]         hit_addr
);

	loc_pair_t               mem [PAIR_ENTRIES];
	logic [PAIR_ENTRIES-1:0] valid_q;
	loc_pair_t               rd_data_s1;
	logic                    ent_valid_s1;
	logic                    vld_s1;
	logic [PW-1:0]           addr_s1;
	logic                    names;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1       <= 1'b0;
			ent_valid_s1 <= 1'b0;
			addr_s1      <= '0;
		end else begin
			vld_s1 <= rd_en;
			if (rd_en) begin
				ent_valid_s1 <= valid_q[rd_addr];
				addr_s1      <= rd_addr;
			end
		end
	end

	assign names = ent_valid_s1 && (rd_data_s1.first == key_b || rd_data_s1.second == key_b);

	always_comb begin
		hit.vld  = vld_s1;
		hit.fwd  = vld_s1 && ent_valid_s1 && rd_data_s1.first == key_a
			&& rd_data_s1.second == key_b;
		hit.rev  = vld_s1 && ent_valid_s1 && rd_data_s1.first == key_b
			&& rd_data_s1.second == key_a;
		hit.free = vld_s1 && !ent_valid_s1;
	end
	assign hit_addr = addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr_all) begin
			valid_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (kill_en && vld_s1 && names) begin
				valid_q[addr_s1] <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/lock_order_checker_unit.sv
// ----------------------------------------------------------------------------
// lock_order_checker_unit
// lock-order checker: held-lock stack and learned pair table, one command per beat
// ----------------------------------------------------------------------------
// in channel (in_valid/in_ready) carries command and object_id; out channel
// (out_valid/out_ready) returns one result beat per command.
// cfg_we/cfg_wdata write the shutting_down bit; the user must do so only while the
// block is idle, the block itself does not enforce it. unlock, clear stack,
// clear graph, unknown commands and all commands while shutting down answer
// straight from idle. lock walks the held stack for the object, then makes one
// sweep of the single-port pair memory per held object through one shared
// comparator, then pushes; remove object makes one sweep of the pair memory.
// one command at a time: in_ready is low while a command runs and while
// its result beat waits; a stalled receiver holds the result and the input.
// reset empties the stack, invalidates all pairs and clears shutting_down;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module lock_order_checker_unit import loc_pkg::*; #(
	parameter int STACK_DEPTH  = 16,
	parameter int PAIR_ENTRIES = 256,
	parameter int OBJECT_BITS  = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire loc_in_t in_data,
	output logic      out_valid,
	input  wire logic out_ready,
	output loc_out_t  out_data,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata
);

	localparam int SW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int PW = $clog2(PAIR_ENTRIES);
	localparam logic [PW-1:0] LAST = PW'(PAIR_ENTRIES - 1);
	localparam logic [OBJ_W-1:0] OBJ_MASK = OBJ_W'((33'd1 << OBJECT_BITS) - 33'd1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_HELD   = 6'b000010,
		S_SWEEP  = 6'b000100,
		S_DECIDE = 6'b001000,
		S_PUSH   = 6'b010000,
		S_REMOVE = 6'b100000
	} state_t;

	state_t           state_q;
	logic             shut_q;
	logic [OBJ_W-1:0] stack_q [STACK_DEPTH];
	logic [CW-1:0]    count_q;
	logic [SW-1:0]    idx_q;
	logic [OBJ_W-1:0] obj_q;
	logic             full_q;
	logic             fwd_q, rev_q, free_found_q;
	logic [PW-1:0]    free_idx_q;
	logic [PW-1:0]    rd_addr_q;
	logic             issuing_q;
	logic             out_valid_q;
	loc_out_t         out_q;

	logic             in_fire;
	logic [OBJ_W-1:0] obj_in;
	logic [SW-1:0]    stack_sel;
	logic [OBJ_W-1:0] stack_rd;
	logic             last_idx;
	logic             rd_en, kill_en, clr_all, wr_en;
	loc_hit_t         hit;
	logic [PW-1:0]    hit_addr;
	logic             sweep_end;
	loc_pair_t        wr_data;

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign obj_in   = in_data.object_id & OBJ_MASK;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// unlock reads the top, the walk reads its own index
	assign stack_sel = (state_q == S_IDLE) ? SW'(count_q - CW'(1)) : idx_q;
	assign stack_rd  = stack_q[stack_sel];
	assign last_idx  = CW'(idx_q) == count_q - CW'(1);

	assign rd_en   = issuing_q && (state_q == S_SWEEP || state_q == S_REMOVE);
	assign kill_en = state_q == S_REMOVE;
	assign clr_all = in_fire && !shut_q && in_data.command == CMD_CLR_GRAPH;
	assign wr_en   = state_q == S_DECIDE && !fwd_q && !rev_q && free_found_q;
	assign sweep_end = hit.vld && hit_addr == LAST;
	assign wr_data.first  = stack_rd;
	assign wr_data.second = obj_q;

	loc_pair_table #(
		.PAIR_ENTRIES(PAIR_ENTRIES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.key_a   (stack_rd),
		.key_b   (obj_q),
		.kill_en (kill_en),
		.clr_all (clr_all),
		.wr_en   (wr_en),
		.wr_addr (free_idx_q),
		.wr_data (wr_data),
		.hit     (hit),
		.hit_addr(hit_addr)
	);

	always_ff @(posedge clk) begin
		if (state_q == S_PUSH && count_q != CW'(STACK_DEPTH)) begin
			stack_q[SW'(count_q)] <= obj_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			shut_q       <= 1'b0;
			count_q      <= '0;
			idx_q        <= '0;
			obj_q        <= '0;
			full_q       <= 1'b0;
			fwd_q        <= 1'b0;
			rev_q        <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			rd_addr_q    <= '0;
			issuing_q    <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_we) begin
				shut_q <= cfg_wdata;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (rd_en) begin
				rd_addr_q <= rd_addr_q + PW'(1);
				if (rd_addr_q == LAST) begin
					issuing_q <= 1'b0;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						obj_q <= obj_in;
						if (shut_q) begin
							out_q       <= '0;
							out_valid_q <= 1'b1;
						end else begin
							unique case (in_data.command)
								CMD_LOCK: begin
									full_q  <= 1'b0;
									idx_q   <= '0;
									state_q <= (count_q == '0) ? S_PUSH : S_HELD;
								end
								CMD_UNLOCK: begin
									out_valid_q <= 1'b1;
									if (count_q == '0) begin
										out_q <= '{status: ST_EMPTY, other_object: '0,
											graph_full: 1'b0};
									end else if (stack_rd != obj_in) begin
										out_q <= '{status: ST_MISORDER, other_object: '0,
											graph_full: 1'b0};
									end else begin
										out_q   <= '0;
										count_q <= count_q - CW'(1);
									end
								end
								CMD_CLR_STACK: begin
									out_q       <= '0;
									out_valid_q <= 1'b1;
									count_q     <= '0;
								end
								CMD_REMOVE: begin
									rd_addr_q <= '0;
									issuing_q <= 1'b1;
									state_q   <= S_REMOVE;
								end
								default: begin
									out_q       <= '0;
									out_valid_q <= 1'b1;
								end
							endcase
						end
					end
				end
				S_HELD: begin
					if (stack_rd == obj_q) begin
						out_q.status       <= ST_HELD;
						out_q.other_object <= obj_q;
						out_q.graph_full   <= 1'b0;
						out_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end else if (last_idx) begin
						idx_q        <= '0;
						rd_addr_q    <= '0;
						issuing_q    <= 1'b1;
						fwd_q        <= 1'b0;
						rev_q        <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= S_SWEEP;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_SWEEP: begin
					if (hit.fwd) begin
						fwd_q <= 1'b1;
					end
					if (hit.rev) begin
						rev_q <= 1'b1;
					end
					if (hit.free && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= hit_addr;
					end
					if (sweep_end) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (fwd_q || !rev_q) begin
						if (!fwd_q && !free_found_q) begin
							full_q <= 1'b1;
						end
						if (last_idx) begin
							state_q <= S_PUSH;
						end else begin
							idx_q        <= idx_q + SW'(1);
							rd_addr_q    <= '0;
							issuing_q    <= 1'b1;
							fwd_q        <= 1'b0;
							rev_q        <= 1'b0;
							free_found_q <= 1'b0;
							state_q      <= S_SWEEP;
						end
					end else begin
						out_q.status       <= ST_ORDER;
						out_q.other_object <= stack_rd;
						out_q.graph_full   <= full_q;
						out_valid_q        <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				S_PUSH: begin
					out_q.other_object <= '0;
					out_q.graph_full   <= full_q;
					out_valid_q        <= 1'b1;
					state_q            <= S_IDLE;
					if (count_q == CW'(STACK_DEPTH)) begin
						out_q.status <= ST_FULL;
					end else begin
						out_q.status <= ST_OK;
						count_q      <= count_q + CW'(1);
					end
				end
				S_REMOVE: begin
					if (sweep_end) begin
						out_q       <= '0;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("held count beyond stack depth");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !wr_en && !clr_all)
		else $error("pair table written during a sweep");

	a_result_ends_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> state_q == S_IDLE)
		else $error("result beat raised while a command still runs");

endmodule

`default_nettype wire

// File: tb/lock_order_checker_unit_test.sv
// ----------------------------------------------------------------------------
// lock_order_checker_unit_test
// drives random lock, unlock, clear, remove and unknown commands, with shutdown
// phases, into the checker under random idling and a long receiver stall; a
// scoreboard tracks the held stack and the pair table and checks every result beat in order
// ----------------------------------------------------------------------------
`default_nettype none

module lock_order_checker_unit_test;
	import loc_pkg::*;

	localparam int DEPTH   = 16;
	localparam int ENTRIES = 256;
	localparam int LIMIT   = 25000000;

	class lock_order_scoreboard;
		logic [OBJ_W-1:0] held [DEPTH];
		int held_n;
		loc_pair_t pairs [ENTRIES];
		bit pair_ok [ENTRIES];
		bit shutting;
		loc_out_t pending [$];
		int errors;

		function new();
			held_n = 0;
			shutting = 0;
			errors = 0;
			foreach (pair_ok[i]) pair_ok[i] = 0;
		endfunction

		function bit known(logic [OBJ_W-1:0] a, logic [OBJ_W-1:0] b);
			foreach (pair_ok[i])
				if (pair_ok[i] && pairs[i].first == a && pairs[i].second == b) return 1;
			return 0;
		endfunction

		function bit learn(logic [OBJ_W-1:0] a, logic [OBJ_W-1:0] b);
			foreach (pair_ok[i])
				if (!pair_ok[i]) begin
					pair_ok[i] = 1;
					pairs[i].first = a;
					pairs[i].second = b;
					return 1;
				end
			return 0;
		endfunction

		function void note_command(loc_in_t c);
			loc_out_t r;
			bit stop;
			r = '0;
			stop = 0;
			if (!shutting) begin
				case (c.command)
					CMD_LOCK: begin
						for (int i = 0; i < held_n && !stop; i++)
							if (held[i] == c.object_id) begin
								r.status = ST_HELD;
								r.other_object = c.object_id;
								stop = 1;
							end
						for (int i = 0; i < held_n && !stop; i++) begin
							if (known(held[i], c.object_id)) continue;
							if (known(c.object_id, held[i])) begin
								r.status = ST_ORDER;
								r.other_object = held[i];
								stop = 1;
							end else if (!learn(held[i], c.object_id))
								r.graph_full = 1;
						end
						if (!stop) begin
							if (held_n >= DEPTH) r.status = ST_FULL;
							else begin
								held[held_n] = c.object_id;
								held_n++;
							end
						end
					end
					CMD_UNLOCK: begin
						if (held_n == 0) r.status = ST_EMPTY;
						else if (held[held_n-1] != c.object_id) r.status = ST_MISORDER;
						else held_n--;
					end
					CMD_CLR_STACK: held_n = 0;
					CMD_CLR_GRAPH: foreach (pair_ok[i]) pair_ok[i] = 0;
					CMD_REMOVE: foreach (pair_ok[i])
						if (pair_ok[i] && (pairs[i].first == c.object_id ||
							pairs[i].second == c.object_id)) pair_ok[i] = 0;
					default: ;
				endcase
			end
			pending.insert(pending.size(), r);
		endfunction

		function void check_result(loc_out_t got);
			loc_out_t exp;
			if (pending.size() == 0) begin
				$display("%0t: result beat with none expected, actual %h", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
				errors++;
			end
			if (got.other_object !== exp.other_object) begin
				$display("%0t: other_object expected %h actual %h", $time,
					exp.other_object, got.other_object);
				errors++;
			end
			if (got.graph_full !== exp.graph_full) begin
				$display("%0t: graph_full expected %b actual %b", $time,
					exp.graph_full, got.graph_full);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	loc_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	loc_out_t out_data;
	logic cfg_we = 0;
	logic cfg_wdata = 0;

	lock_order_checker_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	lock_order_scoreboard sb = new();
	bit calm;
	bit hold_off;
	int cycles;
	logic [OBJ_W-1:0] pool [8];

	always #5 clk = ~clk;

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("lock_order_checker_unit_test: FAIL");
			$finish;
		end
	end

	// receiver: random stalls, long hold-off on request
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
		out_ready <= !hold_off && (calm || $urandom_range(99) >= 13);
	end

	task automatic send(logic [2:0] c, logic [OBJ_W-1:0] o);
		if (!calm)
			while ($urandom_range(99) < 13) begin
				in_valid <= 0;
				@(posedge clk);
			end
		in_valid <= 1;
		in_data <= '{command: c, object_id: o};
		do @(posedge clk); while (!in_ready);
		sb.note_command(in_data);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (ENTRIES * (DEPTH + 2) + 50) @(posedge clk);
	endtask

	task automatic set_shutdown(bit v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.shutting = v;
	endtask

	function automatic logic [OBJ_W-1:0] pick_obj();
		return ($urandom_range(9) == 0) ? OBJ_W'($urandom) : pool[$urandom_range(7)];
	endfunction

	task automatic random_item();
		int k;
		logic [OBJ_W-1:0] o;
		k = $urandom_range(99);
		o = pick_obj();
		if (k < 45) send(CMD_LOCK, o);
		else if (k < 80) begin
			if (sb.held_n > 0 && $urandom_range(9) < 8) o = sb.held[sb.held_n-1];
			send(CMD_UNLOCK, o);
		end else if (k < 88) send(CMD_CLR_STACK, o);
		else if (k < 91) send(CMD_CLR_GRAPH, o);
		else if (k < 97) send(CMD_REMOVE, o);
		else send(3'($urandom_range(7)), o);
	endtask

	initial begin
		calm = 0;
		hold_off = 0;
		foreach (pool[i]) pool[i] = OBJ_W'($urandom);
		pool[0] = '0;
		pool[1] = '1;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty unlock, order learning and violation, held, misorder
		send(CMD_UNLOCK, 16'h0001);
		send(CMD_LOCK, 16'h0000);
		send(CMD_LOCK, 16'hffff);
		send(CMD_LOCK, 16'hffff);
		send(CMD_UNLOCK, 16'h0000);
		send(CMD_CLR_STACK, 16'h0);
		send(CMD_LOCK, 16'hffff);
		send(CMD_LOCK, 16'h0000);
		send(CMD_REMOVE, 16'hffff);
		send(CMD_UNLOCK, 16'hffff);
		send(CMD_LOCK, 16'h0000);
		send(CMD_CLR_GRAPH, 16'h0);
		send(3'd5, 16'h1234);
		send(3'd7, 16'h5678);
		send(CMD_CLR_STACK, 16'h0);
		// fill the stack, then overflow it
		for (int i = 1; i <= DEPTH + 1; i++) send(CMD_LOCK, OBJ_W'(i * 16'h0f0f));
		// stack holds 16 objects: 136 pairs learnt; more locks fill the table
		for (int i = 0; i < 12; i++) send(CMD_LOCK, OBJ_W'(16'h8000 + i));
		send(CMD_CLR_STACK, 16'h0);
		send(CMD_CLR_GRAPH, 16'h0);

		set_shutdown(1);
		send(CMD_LOCK, 16'h0042);
		send(CMD_UNLOCK, 16'h0042);
		set_shutdown(0);

		// long receiver stall with the sender still offering
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			repeat (6) random_item();
		join

		for (int n = 0; n < 1200; n++) begin
			calm = (n >= 300 && n < 450);
			if (n == 600 || n == 1000) set_shutdown(1);
			if (n == 620 || n == 1010) set_shutdown(0);
			if (n % 150 == 149) foreach (pool[i]) pool[i] = OBJ_W'($urandom);
			random_item();
		end
		calm = 0;
		drain();
		if (sb.errors == 0)
			$display("lock_order_checker_unit_test: PASS");
		else
			$display("lock_order_checker_unit_test: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
